/* design/fxalu_pkg.sv */
package fxalu_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int WORD_BITS     = 32;
	localparam int DATA_W        = 32;
	localparam int SAT_BITS      = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
	localparam int NUM_W         = DATA_W + FRACTION_BITS;
	localparam int VAL_W         = 64;

	localparam logic signed [VAL_W-1:0] SAT_MAX = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
	localparam logic signed [VAL_W-1:0] SAT_MIN = -(64'sd1 <<< (SAT_BITS - 1));
	localparam logic [VAL_W-1:0] MUL_HALF = (FRACTION_BITS > 0) ?
		(64'd1 << ((FRACTION_BITS > 0) ? FRACTION_BITS - 1 : 0)) : 64'd0;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	// operands as they enter
	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
		logic [DATA_W-1:0]        ma;
		logic [DATA_W-1:0]        mb;
	} in_t;

	// per-transaction result data carried along the pipe
	typedef struct packed {
		op_t                     op;
		logic                    neg;
		logic                    cmp;
		logic                    sat;
		logic                    dz;
		logic signed [VAL_W-1:0] val;
		logic [VAL_W-1:0]        prod;
	} item_t;

	// restoring divider state
	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [NUM_W-1:0]  nq;
		logic [DATA_W-1:0] den;
	} div_t;

endpackage

/* design/fixed_point_alu.sv */
// signed fixed point alu, FRACTION_BITS fraction bits (Q24.8 as built). one transaction
// is taken on any cycle that start is high; busy never rises, so a new transaction can
// enter every cycle. the pipe length is set by the restoring divider, which retires one
// quotient bit per stage over NUM_W stages; every operation runs through the same pipe
// so results stay in order. done marks the single cycle a result is valid: the receiver
// has to take it then. products and quotients are rounded half away from zero (to_int
// shifts down, toward minus infinity), and results are saturated to the word range, with
// overflow set on saturation; divide by zero sets divide_by_zero and saturates instead.
module fixed_point_alu (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [3:0]                        operation,
	input  logic signed [fxalu_pkg::DATA_W-1:0] operand_a,
	input  logic signed [fxalu_pkg::DATA_W-1:0] operand_b,
	output logic                              done,
	output logic signed [fxalu_pkg::DATA_W-1:0] result_value,
	output logic                              compare_true,
	output logic                              overflow,
	output logic                              divide_by_zero
);
	import fxalu_pkg::*;

	localparam int LAT = NUM_W + 5;

	// no stall path: the pipe always moves
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// stage 1: capture operands and their magnitudes
	in_t  in_d, in_s1;
	logic v_s1;

	always_comb begin
		in_d.op = op_t'(operation);
		in_d.a  = operand_a;
		in_d.b  = operand_b;
		in_d.ma = operand_a[DATA_W-1] ? (~operand_a + 1'b1) : operand_a;
		in_d.mb = operand_b[DATA_W-1] ? (~operand_b + 1'b1) : operand_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= in_d;
	end

	// stage 2: simple ops finish here, multiply product, divider setup
	item_t it_d, it_s2;
	div_t  dv_d, dv_s2;
	logic  v_s2;
	logic signed [VAL_W-1:0] ax, bx;

	always_comb begin
		ax = VAL_W'(in_s1.a);
		bx = VAL_W'(in_s1.b);
		it_d.op   = in_s1.op;
		it_d.neg  = in_s1.a[DATA_W-1] ^ in_s1.b[DATA_W-1];
		it_d.cmp  = 1'b0;
		it_d.sat  = 1'b1;
		it_d.dz   = 1'b0;
		it_d.val  = '0;
		it_d.prod = VAL_W'(in_s1.ma) * VAL_W'(in_s1.mb);
		case (in_s1.op)
			OP_ADD:      it_d.val = ax + bx;
			OP_SUB:      it_d.val = ax - bx;
			OP_MUL:      it_d.val = '0;
			OP_DIV: begin
				if (in_s1.b == '0) begin
					it_d.dz  = 1'b1;
					it_d.sat = 1'b0;
					it_d.val = in_s1.a[DATA_W-1] ? SAT_MIN : SAT_MAX;
				end
			end
			OP_GT:       it_d.cmp = ax > bx;
			OP_LT:       it_d.cmp = ax < bx;
			OP_GE:       it_d.cmp = ax >= bx;
			OP_LE:       it_d.cmp = ax <= bx;
			OP_EQ:       it_d.cmp = ax == bx;
			OP_NE:       it_d.cmp = ax != bx;
			OP_MIN:      it_d.val = (ax < bx) ? ax : bx;
			OP_MAX:      it_d.val = (ax > bx) ? ax : bx;
			OP_INC:      it_d.val = ax + 64'sd1;
			OP_DEC:      it_d.val = ax - 64'sd1;
			OP_FROM_INT: it_d.val = ax <<< FRACTION_BITS;
			OP_TO_INT:   it_d.val = ax >>> FRACTION_BITS;
			default:     it_d.val = '0;
		endcase
		// numerator is |a| scaled by the fraction, fed msb first
		dv_d.rem = '0;
		dv_d.nq  = NUM_W'(in_s1.ma) << FRACTION_BITS;
		dv_d.den = in_s1.mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s2 <= it_d;
		dv_s2 <= dv_d;
	end

	// divider stages: one quotient bit each; multiply round and sign ride along
	item_t it_dv_s [NUM_W];
	div_t  dv_dv_s [NUM_W];
	logic  v_dv_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_div
		item_t it_p, it_n;
		div_t  dv_p, dv_n;
		logic  v_p;
		logic [DATA_W:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign it_p = it_s2;
			assign dv_p = dv_s2;
			assign v_p  = v_s2;
		end else begin : g_next
			assign it_p = it_dv_s[k-1];
			assign dv_p = dv_dv_s[k-1];
			assign v_p  = v_dv_s[k-1];
		end

		always_comb begin
			it_n = it_p;
			if (k == 0 && it_p.op == OP_MUL) begin
				it_n.prod = (it_p.prod + MUL_HALF) >> FRACTION_BITS;
			end
			if (k == 1 && it_p.op == OP_MUL) begin
				it_n.val = it_p.neg ? -$signed(it_p.prod) : $signed(it_p.prod);
			end
			trial    = {dv_p.rem, dv_p.nq[NUM_W-1]};
			ge       = trial >= {1'b0, dv_p.den};
			dv_n.den = dv_p.den;
			dv_n.rem = ge ? DATA_W'(trial - {1'b0, dv_p.den}) : trial[DATA_W-1:0];
			dv_n.nq  = {dv_p.nq[NUM_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv_s[k] <= 1'b0;
			end else begin
				v_dv_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			it_dv_s[k] <= it_n;
			dv_dv_s[k] <= dv_n;
		end
	end

	// round stage: quotient plus one when twice the remainder reaches the divisor
	item_t it_rnd_d, it_rnd_s;
	logic  v_rnd_s;
	logic  is_div_l;
	logic  up;

	always_comb begin
		is_div_l = (it_dv_s[NUM_W-1].op == OP_DIV) && !it_dv_s[NUM_W-1].dz;
		up       = {dv_dv_s[NUM_W-1].rem, 1'b0} >= {1'b0, dv_dv_s[NUM_W-1].den};
		it_rnd_d = it_dv_s[NUM_W-1];
		if (is_div_l) begin
			it_rnd_d.prod = VAL_W'(dv_dv_s[NUM_W-1].nq) + VAL_W'(up);
		end
	end

	// sign stage
	item_t it_sgn_d, it_sgn_s;
	logic  v_sgn_s;

	always_comb begin
		it_sgn_d = it_rnd_s;
		if (it_rnd_s.op == OP_DIV && !it_rnd_s.dz) begin
			it_sgn_d.val = it_rnd_s.neg ? -$signed(it_rnd_s.prod) : $signed(it_rnd_s.prod);
		end
	end

	// saturate into the output register
	logic signed [VAL_W-1:0] sat_val;
	logic                    sat_ovf;

	always_comb begin
		sat_val = it_sgn_s.val;
		sat_ovf = 1'b0;
		if (it_sgn_s.sat) begin
			if (it_sgn_s.val > SAT_MAX) begin
				sat_val = SAT_MAX;
				sat_ovf = 1'b1;
			end else if (it_sgn_s.val < SAT_MIN) begin
				sat_val = SAT_MIN;
				sat_ovf = 1'b1;
			end
		end
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_rnd_s <= 1'b0;
			v_sgn_s <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_rnd_s <= v_dv_s[NUM_W-1];
			v_sgn_s <= v_rnd_s;
			done_q  <= v_sgn_s;
		end
	end

	logic signed [DATA_W-1:0] result_q;
	logic                     cmp_q;
	logic                     ovf_q;
	logic                     dz_q;

	always_ff @(posedge clk) begin
		it_rnd_s <= it_rnd_d;
		it_sgn_s <= it_sgn_d;
		result_q <= sat_val[DATA_W-1:0];
		cmp_q    <= it_sgn_s.cmp;
		ovf_q    <= sat_ovf;
		dz_q     <= it_sgn_s.dz;
	end

	assign done           = done_q;
	assign result_value   = result_q;
	assign compare_true   = cmp_q;
	assign overflow       = ovf_q;
	assign divide_by_zero = dz_q;

	// every result traces back to an accepted transaction
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without matching transaction");

	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> !overflow && !compare_true)
		else $error("divide by zero with overflow or compare");

	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && compare_true |-> result_value == '0)
		else $error("compare result not zero");

	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && overflow |->
			(VAL_W'(result_value) == SAT_MAX) || (VAL_W'(result_value) == SAT_MIN))
		else $error("overflow without saturated value");

endmodule
